### rtl/core/isotp_pkg.sv
// ----------------------------------------------------------------------------
// isotp_pkg
// Shared types, codes and helpers of the ISO-TP UDS response receiver.
// ----------------------------------------------------------------------------
package isotp_pkg;

   localparam int PAYLOAD_MAX_DEF = 64;

   localparam int CMD_W      = 2;
   localparam int FID_W      = 29;
   localparam int FLEN_W     = 4;
   localparam int FDATA_W    = 64;
   localparam int RSP_ID_W   = 11;
   localparam int MAXP_W     = 4;
   localparam int SEQ_W      = 4;
   localparam int PLEN_W     = 7;
   localparam int CLS_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int BIDX_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam int REQ_TDATA_W = 104;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 1;

   localparam logic [CMD_W-1:0] CMD_FRAME   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ARM     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ABANDON = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_ID = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PENDING = 1'd1;

   localparam logic [RSP_ID_W-1:0] RESPONSE_ID_RST = 11'd2024;
   localparam logic [MAXP_W-1:0]   MAX_PENDING_RST = 4'd4;

   localparam logic [BYTE_W-1:0] PCI_TYPE_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] PCI_SF        = 8'h00;
   localparam logic [BYTE_W-1:0] PCI_FF        = 8'h10;
   localparam logic [BYTE_W-1:0] PCI_CF        = 8'h20;
   localparam logic [BYTE_W-1:0] SID_NEG_RSP   = 8'h7F;
   localparam logic [BYTE_W-1:0] NRC_PENDING   = 8'h78;
   localparam logic [BYTE_W-1:0] RSP_RDBI      = 8'h62;
   localparam logic [BYTE_W-1:0] RSP_RDTC      = 8'h59;
   localparam logic [BYTE_W-1:0] SID_RDBI      = 8'h22;
   localparam logic [BYTE_W-1:0] SID_RDTC      = 8'h19;

   localparam logic [CLS_W-1:0] CLS_NONE  = 3'd0;
   localparam logic [CLS_W-1:0] CLS_READ  = 3'd1;
   localparam logic [CLS_W-1:0] CLS_DTC   = 3'd2;
   localparam logic [CLS_W-1:0] CLS_NEG   = 3'd3;
   localparam logic [CLS_W-1:0] CLS_PEND  = 3'd4;
   localparam logic [CLS_W-1:0] CLS_UNREC = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WRITE,
      ST_CLASSIFY,
      ST_FETCH,
      ST_PUSH
   } ctl_state_type;

   typedef enum logic [1:0] {
      ACT_EMIT,
      ACT_WRITE,
      ACT_CLASSIFY
   } act_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic write;
      logic classify;
      logic push;
   } ctl_cmd_type;

   typedef struct packed {
      act_type act;
      logic    wr_idle;
      logic    emit_last;
      logic    out_free;
   } dp_status_type;

   function automatic logic [BYTE_W-1:0] frame_byte(input logic [FDATA_W-1:0] data,
                                                    input logic [BIDX_W-1:0]  idx);
      logic [BIDX_W-1:0] rev;
      rev = 3'd7 - idx;
      return data[{rev, 3'b000} +: BYTE_W];
   endfunction

endpackage

### rtl/core/isotp_uds_response_receiver.sv
// ----------------------------------------------------------------------------
// isotp_uds_response_receiver
// ISO-TP receive reassembly and classification of one UDS response.
// ----------------------------------------------------------------------------
// One request transfer is handled at a time. After decode, a first or
// consecutive frame writes the payload RAM one byte per cycle (up to 7 bytes
// for a consecutive frame, 6 for a first frame); a single frame and a reassembly
// go on to classification. Every result transfer passes through the registered
// RAM read and the output register, and stalls while rsp_tready is low. An arm,
// abandon or ignored frame goes from decode straight to its result transfer. The
// payload RAM has a single write port and a registered read. The output
// register holds the final result while the next request is accepted.
// ----------------------------------------------------------------------------
module isotp_uds_response_receiver #(
   parameter int PAYLOAD_MAX = isotp_pkg::PAYLOAD_MAX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [isotp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [isotp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // frame_id, frame_length, frame_data, zero pad
   input  logic [isotp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // command, is_extended, is_remote
   input  logic [isotp_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // payload_byte, frame_taken, send_flow_control, sequence_error,
   // response_class, payload_length, request_done, zero pad
   output logic [isotp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // byte_valid
   output logic [isotp_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   output logic                                 rsp_tlast
);

   isotp_pkg::ctl_cmd_type   cmd;
   isotp_pkg::dp_status_type status;

   isotp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   isotp_dp #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/core/isotp_ctrl.sv
// ----------------------------------------------------------------------------
// isotp_ctrl
// Sequencer: decode, store write, classification and result transfer steps.
// ----------------------------------------------------------------------------
module isotp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  isotp_pkg::dp_status_type status,
   output isotp_pkg::ctl_cmd_type   cmd
);

   isotp_pkg::ctl_state_type state_ff;
   isotp_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isotp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         isotp_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = isotp_pkg::ST_DECODE;
         end
         isotp_pkg::ST_DECODE: begin
            unique case (status.act)
               isotp_pkg::ACT_WRITE:    state_in = isotp_pkg::ST_WRITE;
               isotp_pkg::ACT_CLASSIFY: state_in = isotp_pkg::ST_CLASSIFY;
               default:                 state_in = isotp_pkg::ST_FETCH;
            endcase
         end
         isotp_pkg::ST_WRITE: begin
            if (status.wr_idle) state_in = isotp_pkg::ST_CLASSIFY;
         end
         isotp_pkg::ST_CLASSIFY: begin
            state_in = isotp_pkg::ST_FETCH;
         end
         isotp_pkg::ST_FETCH: begin
            state_in = isotp_pkg::ST_PUSH;
         end
         isotp_pkg::ST_PUSH: begin
            if (status.out_free) begin
               state_in = status.emit_last ? isotp_pkg::ST_IDLE : isotp_pkg::ST_FETCH;
            end
         end
         default: state_in = isotp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == isotp_pkg::ST_IDLE);
      cmd.capture  = (state_ff == isotp_pkg::ST_IDLE) && req_tvalid;
      cmd.decode   = (state_ff == isotp_pkg::ST_DECODE);
      cmd.write    = (state_ff == isotp_pkg::ST_WRITE);
      cmd.classify = (state_ff == isotp_pkg::ST_CLASSIFY);
      cmd.push     = (state_ff == isotp_pkg::ST_PUSH) && status.out_free;
   end

endmodule

### rtl/core/isotp_dp.sv
// ----------------------------------------------------------------------------
// isotp_dp
// Datapath: frame decode, reassembly state, payload RAM, classifier and
// result output register.
// ----------------------------------------------------------------------------
module isotp_dp #(
   parameter int PAYLOAD_MAX = isotp_pkg::PAYLOAD_MAX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [isotp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [isotp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [isotp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [isotp_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  isotp_pkg::ctl_cmd_type               cmd,
   output isotp_pkg::dp_status_type             status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [isotp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [isotp_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int ADDR_W = $clog2(PAYLOAD_MAX);
   localparam int LEN_W  = $clog2(PAYLOAD_MAX + 1);
   localparam int BW     = isotp_pkg::BYTE_W;
   localparam int BIDX_W = isotp_pkg::BIDX_W;
   localparam int SEQ_W  = isotp_pkg::SEQ_W;

   // configuration
   logic [isotp_pkg::RSP_ID_W-1:0] resp_id_ff;
   logic [isotp_pkg::MAXP_W-1:0]   max_pend_ff;

   // captured request
   logic [isotp_pkg::CMD_W-1:0]   in_cmd_ff;
   logic                          in_ext_ff;
   logic                          in_rtr_ff;
   logic [isotp_pkg::FID_W-1:0]   in_fid_ff;
   logic [isotp_pkg::FLEN_W-1:0]  in_flen_ff;
   logic [isotp_pkg::FDATA_W-1:0] in_data_ff;

   // reassembly state
   logic                 waiting_ff, waiting_in;
   logic [LEN_W-1:0]     exp_ff, exp_in;
   logic [LEN_W-1:0]     rcv_ff, rcv_in;
   logic [SEQ_W-1:0]     nseq_ff, nseq_in;
   logic [SEQ_W-1:0]     pend_ff, pend_in;
   logic [BW-1:0]        head_ff [3];
   logic [BW-1:0]        head_in [3];

   // store write sequencing
   logic [BIDX_W-1:0]    wr_left_ff, wr_left_in;
   logic [ADDR_W-1:0]    wr_addr_ff, wr_addr_in;
   logic [BIDX_W-1:0]    wr_src_ff, wr_src_in;
   logic [BW-1:0]        wr_byte;
   logic                 wr_fire;

   // result of the current request
   logic                       taken_ff, taken_in;
   logic                       fc_ff, fc_in;
   logic                       seqerr_ff, seqerr_in;
   logic [isotp_pkg::CLS_W-1:0] cls_ff, cls_in;
   logic                       done_ff, done_in;
   logic                       have_ff, have_in;
   logic                       single_ff, single_in;
   logic [LEN_W-1:0]           plen_ff, plen_in;
   logic [LEN_W-1:0]           k_ff, k_in;

   // payload RAM
   logic [BW-1:0] store_mem [PAYLOAD_MAX];
   logic [BW-1:0] rd_data_ff;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [isotp_pkg::RSP_TDATA_W-1:0]   rsp_data_ff;
   logic                                rsp_user_ff;
   logic                                rsp_last_ff;

   // decode terms
   logic [isotp_pkg::FLEN_W-1:0] flen_c;
   logic [BW-1:0]                pci;
   logic [BW-1:0]                pci_type;
   logic                         frame_ok;
   logic                         seq_ok;
   logic [isotp_pkg::FLEN_W-1:0] sf_lim;
   logic [isotp_pkg::FLEN_W-1:0] sf_n;
   logic [11:0]                  ff_exp12;
   logic [LEN_W-1:0]             ff_exp;
   logic [LEN_W-1:0]             ff_room;
   logic [LEN_W-1:0]             ff_n;
   logic [LEN_W-1:0]             cf_rem;
   logic [LEN_W-1:0]             cf_room;
   logic [LEN_W-1:0]             cf_n;
   isotp_pkg::act_type           act;

   // classify terms
   logic [BW-1:0]               p0, p1, p2;
   logic [LEN_W-1:0]            cl_plen;
   logic                        cl_complete;
   logic [isotp_pkg::CLS_W-1:0] cl_cls;
   logic                        cl_ends;
   logic                        cl_pend;

   // emit terms
   logic             emit_valid;
   logic [LEN_W-1:0] emit_cnt;
   logic             emit_last;
   logic [BW-1:0]    emit_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         resp_id_ff  <= isotp_pkg::RESPONSE_ID_RST;
         max_pend_ff <= isotp_pkg::MAX_PENDING_RST;
      end else if (csr_we) begin
         if (csr_index == isotp_pkg::CSR_RESPONSE_ID) begin
            resp_id_ff <= csr_wdata;
         end
         if (csr_index == isotp_pkg::CSR_MAX_PENDING) begin
            max_pend_ff <= csr_wdata[isotp_pkg::MAXP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_cmd_ff  <= req_tuser[1:0];
         in_ext_ff  <= req_tuser[2];
         in_rtr_ff  <= req_tuser[3];
         in_fid_ff  <= req_tdata[28:0];
         in_flen_ff <= req_tdata[32:29];
         in_data_ff <= req_tdata[96:33];
      end
   end

   always_comb begin
      flen_c   = (in_flen_ff > 4'd8) ? 4'd8 : in_flen_ff;
      pci      = isotp_pkg::frame_byte(in_data_ff, 3'd0);
      pci_type = pci & isotp_pkg::PCI_TYPE_MASK;
      frame_ok = (in_cmd_ff == isotp_pkg::CMD_FRAME) && waiting_ff && !in_rtr_ff &&
                 !in_ext_ff && (in_fid_ff == isotp_pkg::FID_W'(resp_id_ff)) &&
                 (flen_c >= 4'd2);
      seq_ok   = (pci[3:0] == nseq_ff);
      sf_lim   = flen_c - 4'd1;
      sf_n     = (pci[3:0] > sf_lim) ? sf_lim : pci[3:0];
      ff_exp12 = {pci[3:0], isotp_pkg::frame_byte(in_data_ff, 3'd1)};
      ff_exp   = (ff_exp12 > 12'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX) : LEN_W'(ff_exp12);
      ff_room  = LEN_W'(flen_c - 4'd2);
      ff_n     = (ff_room > ff_exp) ? ff_exp : ff_room;
      cf_rem   = (exp_ff > rcv_ff) ? (exp_ff - rcv_ff) : '0;
      cf_room  = LEN_W'(flen_c - 4'd1);
      cf_n     = (cf_room > cf_rem) ? cf_rem : cf_room;

      act = isotp_pkg::ACT_EMIT;
      if (frame_ok) begin
         if (pci_type == isotp_pkg::PCI_SF) begin
            act = isotp_pkg::ACT_CLASSIFY;
         end else if ((pci_type == isotp_pkg::PCI_FF) && (flen_c >= 4'd3)) begin
            act = isotp_pkg::ACT_WRITE;
         end else if ((pci_type == isotp_pkg::PCI_CF) && (exp_ff != '0) && seq_ok) begin
            act = isotp_pkg::ACT_WRITE;
         end
      end
   end

   always_comb begin
      p0 = single_ff ? isotp_pkg::frame_byte(in_data_ff, 3'd1) : head_ff[0];
      p1 = single_ff ? isotp_pkg::frame_byte(in_data_ff, 3'd2) : head_ff[1];
      p2 = single_ff ? isotp_pkg::frame_byte(in_data_ff, 3'd3) : head_ff[2];
      cl_plen     = single_ff ? plen_ff : rcv_ff;
      cl_complete = single_ff || (rcv_ff >= exp_ff);
      cl_cls  = isotp_pkg::CLS_UNREC;
      cl_ends = 1'b0;
      cl_pend = 1'b0;
      if (cl_plen == '0) begin
         cl_cls = isotp_pkg::CLS_UNREC;
      end else if (p0 == isotp_pkg::SID_NEG_RSP) begin
         if ((cl_plen < LEN_W'(2)) ||
             ((p1 != isotp_pkg::SID_RDBI) && (p1 != isotp_pkg::SID_RDTC))) begin
            cl_cls = isotp_pkg::CLS_UNREC;
         end else if ((cl_plen >= LEN_W'(3)) && (p2 == isotp_pkg::NRC_PENDING) &&
                      (pend_ff < max_pend_ff)) begin
            cl_cls  = isotp_pkg::CLS_PEND;
            cl_pend = 1'b1;
         end else begin
            cl_cls  = isotp_pkg::CLS_NEG;
            cl_ends = 1'b1;
         end
      end else if (p0 == isotp_pkg::RSP_RDBI) begin
         cl_cls  = isotp_pkg::CLS_READ;
         cl_ends = 1'b1;
      end else if (p0 == isotp_pkg::RSP_RDTC) begin
         cl_cls  = isotp_pkg::CLS_DTC;
         cl_ends = 1'b1;
      end
   end

   always_comb begin
      emit_valid = have_ff && (plen_ff != '0);
      emit_cnt   = emit_valid ? plen_ff : LEN_W'(1);
      emit_last  = (k_ff == (emit_cnt - LEN_W'(1)));
      if (!emit_valid) begin
         emit_byte = '0;
      end else if (single_ff) begin
         emit_byte = isotp_pkg::frame_byte(in_data_ff, BIDX_W'(k_ff + LEN_W'(1)));
      end else begin
         emit_byte = rd_data_ff;
      end
   end

   assign wr_byte = isotp_pkg::frame_byte(in_data_ff, wr_src_ff);
   assign wr_fire = cmd.write && (wr_left_ff != '0);

   always_comb begin
      waiting_in = waiting_ff;
      exp_in     = exp_ff;
      rcv_in     = rcv_ff;
      nseq_in    = nseq_ff;
      pend_in    = pend_ff;
      head_in    = head_ff;
      wr_left_in = wr_left_ff;
      wr_addr_in = wr_addr_ff;
      wr_src_in  = wr_src_ff;
      taken_in   = taken_ff;
      fc_in      = fc_ff;
      seqerr_in  = seqerr_ff;
      cls_in     = cls_ff;
      done_in    = done_ff;
      have_in    = have_ff;
      single_in  = single_ff;
      plen_in    = plen_ff;
      k_in       = k_ff;

      if (cmd.decode) begin
         taken_in   = 1'b0;
         fc_in      = 1'b0;
         seqerr_in  = 1'b0;
         cls_in     = isotp_pkg::CLS_NONE;
         done_in    = 1'b0;
         have_in    = 1'b0;
         single_in  = 1'b0;
         plen_in    = '0;
         k_in       = '0;
         wr_left_in = '0;
         if (in_cmd_ff == isotp_pkg::CMD_ARM) begin
            exp_in     = '0;
            rcv_in     = '0;
            nseq_in    = SEQ_W'(1);
            pend_in    = '0;
            waiting_in = 1'b1;
         end else if (in_cmd_ff == isotp_pkg::CMD_ABANDON) begin
            done_in    = waiting_ff;
            waiting_in = 1'b0;
            exp_in     = '0;
            rcv_in     = '0;
            nseq_in    = SEQ_W'(1);
            pend_in    = '0;
         end else if (frame_ok) begin
            if (pci_type == isotp_pkg::PCI_SF) begin
               single_in = 1'b1;
               plen_in   = LEN_W'(sf_n);
            end else if ((pci_type == isotp_pkg::PCI_FF) && (flen_c >= 4'd3)) begin
               exp_in     = ff_exp;
               rcv_in     = ff_n;
               nseq_in    = SEQ_W'(1);
               taken_in   = 1'b1;
               fc_in      = 1'b1;
               wr_left_in = BIDX_W'(ff_n);
               wr_addr_in = '0;
               wr_src_in  = BIDX_W'(2);
            end else if ((pci_type == isotp_pkg::PCI_CF) && (exp_ff != '0)) begin
               taken_in = 1'b1;
               if (!seq_ok) begin
                  seqerr_in  = 1'b1;
                  done_in    = 1'b1;
                  waiting_in = 1'b0;
                  exp_in     = '0;
                  rcv_in     = '0;
                  nseq_in    = SEQ_W'(1);
                  pend_in    = '0;
               end else begin
                  nseq_in    = nseq_ff + SEQ_W'(1);
                  wr_left_in = BIDX_W'(cf_n);
                  wr_addr_in = rcv_ff[ADDR_W-1:0];
                  wr_src_in  = BIDX_W'(1);
                  rcv_in     = rcv_ff + cf_n;
               end
            end
         end
      end

      if (wr_fire) begin
         wr_left_in = wr_left_ff - BIDX_W'(1);
         wr_addr_in = wr_addr_ff + ADDR_W'(1);
         wr_src_in  = wr_src_ff + BIDX_W'(1);
         if (wr_addr_ff < ADDR_W'(3)) begin
            head_in[wr_addr_ff[1:0]] = wr_byte;
         end
      end

      if (cmd.classify && cl_complete) begin
         have_in = 1'b1;
         plen_in = cl_plen;
         cls_in  = cl_cls;
         if (cl_pend) begin
            pend_in = pend_ff + SEQ_W'(1);
         end
         if (cl_ends) begin
            taken_in   = 1'b1;
            done_in    = 1'b1;
            waiting_in = 1'b0;
            exp_in     = '0;
            rcv_in     = '0;
            nseq_in    = SEQ_W'(1);
            pend_in    = '0;
         end
      end

      if (cmd.push) begin
         k_in = k_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         exp_ff     <= '0;
         rcv_ff     <= '0;
         nseq_ff    <= SEQ_W'(1);
         pend_ff    <= '0;
      end else begin
         waiting_ff <= waiting_in;
         exp_ff     <= exp_in;
         rcv_ff     <= rcv_in;
         nseq_ff    <= nseq_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff    <= head_in;
      wr_left_ff <= wr_left_in;
      wr_addr_ff <= wr_addr_in;
      wr_src_ff  <= wr_src_in;
      taken_ff   <= taken_in;
      fc_ff      <= fc_in;
      seqerr_ff  <= seqerr_in;
      cls_ff     <= cls_in;
      done_ff    <= done_in;
      have_ff    <= have_in;
      single_ff  <= single_in;
      plen_ff    <= plen_in;
      k_ff       <= k_in;
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         store_mem[wr_addr_ff] <= wr_byte;
      end
      rd_data_ff <= store_mem[k_ff[ADDR_W-1:0]];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff <= {2'b00, done_ff,
                         have_ff ? isotp_pkg::PLEN_W'(plen_ff) : isotp_pkg::PLEN_W'(0),
                         cls_ff, seqerr_ff, fc_ff, taken_ff, emit_byte};
         rsp_user_ff <= emit_valid;
         rsp_last_ff <= emit_last;
      end
   end

   always_comb begin
      status.act       = act;
      status.wr_idle   = (wr_left_ff == '0);
      status.emit_last = emit_last;
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/core/isotp_chk.sv
// ----------------------------------------------------------------------------
// isotp_chk
// Port-level checks of the ISO-TP UDS response receiver, bound to the top.
// ----------------------------------------------------------------------------
module isotp_chk (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [isotp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic [isotp_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   input logic                                 rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in progress");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("result without payload byte is not last");

   a_fc_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[8])
      else $error("flow control requested for frame not taken");

   a_seqerr_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[21] && rsp_tdata[8])
      else $error("sequence error without request end");

endmodule

bind isotp_uds_response_receiver isotp_chk u_isotp_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### bench/isotp_uds_response_receiver_tb.sv
// ----------------------------------------------------------------------------
// isotp_uds_response_receiver_tb
// Self-checking bench for ISO-TP reassembly and UDS response classification.
// ----------------------------------------------------------------------------
// A directed list covers single, first and consecutive frames, every command,
// ignored frames, length clamps, empty payloads, pending replies and sequence
// errors. Random phases then send mostly well-formed requests with random
// content under several register settings, mixed with noise and broken
// transfers. A behavioral reassembler predicts every output transfer, which
// is checked field by field. Both stream sides idle at random, and the output
// side holds off once for a long stretch so the input side backs up.
// ----------------------------------------------------------------------------
module isotp_uds_response_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import isotp_pkg::*;

   localparam int PMAX           = PAYLOAD_MAX_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [FID_W-1:0]   frame_id;
      logic               is_extended;
      logic               is_remote;
      logic [FLEN_W-1:0]  frame_length;
      logic [FDATA_W-1:0] frame_data;
   } can_frame_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              byte_valid;
      logic              last;
      logic              frame_taken;
      logic              send_fc;
      logic              seq_err;
      logic [CLS_W-1:0]  cls;
      logic [PLEN_W-1:0] plen;
      logic              done;
   } uds_reply_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   isotp_uds_response_receiver #(
      .PAYLOAD_MAX(PMAX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // behavioral reassembler state
   logic [RSP_ID_W-1:0] cfg_response_id = RESPONSE_ID_RST;
   logic [MAXP_W-1:0]   cfg_max_pending = MAX_PENDING_RST;
   bit                  rx_waiting = 1'b0;
   int                  rx_expected = 0;
   int                  rx_received = 0;
   logic [SEQ_W-1:0]    rx_next_seq = 4'd1;
   logic [MAXP_W-1:0]   rx_pending = '0;
   logic [BYTE_W-1:0]   rx_store [PMAX];

   can_frame_type can_frame_q [$];
   uds_reply_type uds_reply_q [$];
   can_frame_type cur_frame;

   int frames_planned = 0;
   int frames_sent = 0;
   int results_checked = 0;
   int bytes_seen = 0;
   int seq_errors = 0;
   int fc_requests = 0;
   int mismatches = 0;
   int cls_seen [8];
   int burst_left = 0;
   int gap_left = 0;
   int holdoff_token = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;
   int stall_mode = 0;
   int stall_cyc = 0;
   int watchdog = 0;
   bit ready_next;
   uds_reply_type got_rsp;
   uds_reply_type want_rsp;

   function automatic logic [7:0] data_byte(input logic [63:0] d, input int i);
      return d[(7 - i) * 8 +: 8];
   endfunction

   function automatic logic [63:0] put_byte(input logic [63:0] d, input int i,
                                            input logic [7:0] b);
      d[(7 - i) * 8 +: 8] = b;
      return d;
   endfunction

   task automatic drop_transfer();
      rx_waiting  = 1'b0;
      rx_expected = 0;
      rx_received = 0;
      rx_next_seq = 4'd1;
      rx_pending  = '0;
   endtask

   task automatic reassemble_frame(input can_frame_type f);
      logic [BYTE_W-1:0] pay [PMAX];
      logic [BYTE_W-1:0] pci;
      logic [CLS_W-1:0]  cls;
      int                flen, plen, n, rem, cnt;
      bit                have, complete, taken, fc, seqerr, done, ends;
      uds_reply_type     r;
      have = 0; complete = 0; taken = 0; fc = 0; seqerr = 0; done = 0; ends = 0;
      cls = CLS_NONE;
      plen = 0;
      flen = (f.frame_length > 8) ? 8 : int'(f.frame_length);
      pci = f.frame_data[63:56];
      if (f.command == CMD_ARM) begin
         drop_transfer();
         rx_waiting = 1'b1;
      end else if (f.command == CMD_ABANDON) begin
         done = rx_waiting;
         drop_transfer();
      end else if (f.command == CMD_FRAME && rx_waiting && !f.is_remote && !f.is_extended
                   && f.frame_id == {18'd0, cfg_response_id} && flen >= 2) begin
         if ((pci & PCI_TYPE_MASK) == PCI_SF) begin
            n = int'(pci[3:0]);
            if (n > flen - 1) n = flen - 1;
            for (int i = 0; i < n; i++) pay[i] = data_byte(f.frame_data, i + 1);
            plen = n;
            complete = 1;
         end else if ((pci & PCI_TYPE_MASK) == PCI_FF && flen >= 3) begin
            rx_expected = int'({pci[3:0], f.frame_data[55:48]});
            if (rx_expected > PMAX) rx_expected = PMAX;
            n = flen - 2;
            if (n > rx_expected) n = rx_expected;
            for (int i = 0; i < n; i++) rx_store[i] = data_byte(f.frame_data, i + 2);
            rx_received = n;
            rx_next_seq = 4'd1;
            taken = 1;
            fc = 1;
            complete = (rx_received >= rx_expected);
         end else if ((pci & PCI_TYPE_MASK) == PCI_CF && rx_expected > 0) begin
            taken = 1;
            if (pci[3:0] != rx_next_seq) begin
               seqerr = 1;
               done = 1;
               drop_transfer();
            end else begin
               rx_next_seq = rx_next_seq + 4'd1;
               rem = (rx_expected > rx_received) ? rx_expected - rx_received : 0;
               n = flen - 1;
               if (n > rem) n = rem;
               for (int i = 0; i < n; i++)
                  rx_store[rx_received + i] = data_byte(f.frame_data, i + 1);
               rx_received += n;
               complete = (rx_received >= rx_expected);
            end
         end
         if (complete) begin
            if ((pci & PCI_TYPE_MASK) != PCI_SF) begin
               plen = rx_received;
               for (int i = 0; i < plen; i++) pay[i] = rx_store[i];
            end
            have = 1;
            if (plen == 0) begin
               cls = CLS_UNREC;
            end else if (pay[0] == SID_NEG_RSP) begin
               if (plen < 2 || (pay[1] != SID_RDBI && pay[1] != SID_RDTC)) begin
                  cls = CLS_UNREC;
               end else if (plen >= 3 && pay[2] == NRC_PENDING
                            && rx_pending < cfg_max_pending) begin
                  rx_pending = rx_pending + 4'd1;
                  cls = CLS_PEND;
               end else begin
                  cls = CLS_NEG;
                  ends = 1;
               end
            end else if (pay[0] == RSP_RDBI) begin
               cls = CLS_READ;
               ends = 1;
            end else if (pay[0] == RSP_RDTC) begin
               cls = CLS_DTC;
               ends = 1;
            end else begin
               cls = CLS_UNREC;
            end
            if (ends) begin
               taken = 1;
               done = 1;
               drop_transfer();
            end
         end
      end
      cnt = (have && plen > 0) ? plen : 1;
      for (int k = 0; k < cnt; k++) begin
         r.payload_byte = (have && plen > 0) ? pay[k] : 8'd0;
         r.byte_valid   = have && plen > 0;
         r.last         = (k == cnt - 1);
         r.frame_taken  = taken;
         r.send_fc      = fc;
         r.seq_err      = seqerr;
         r.cls          = cls;
         r.plen         = PLEN_W'(have ? plen : 0);
         r.done         = done;
         uds_reply_q.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            reassemble_frame(cur_frame);
            frames_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (can_frame_q.size() > 0) begin
               cur_frame = can_frame_q.pop_front();
               req_tdata <= {7'd0, cur_frame.frame_data, cur_frame.frame_length,
                             cur_frame.frame_id};
               req_tuser <= {cur_frame.is_remote, cur_frame.is_extended, cur_frame.command};
               req_tvalid <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on transfer %0d: %s expected %0h got %0h",
                     results_checked, name, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.payload_byte = rsp_tdata[7:0];
            got_rsp.frame_taken  = rsp_tdata[8];
            got_rsp.send_fc      = rsp_tdata[9];
            got_rsp.seq_err      = rsp_tdata[10];
            got_rsp.cls          = rsp_tdata[13:11];
            got_rsp.plen         = rsp_tdata[20:14];
            got_rsp.done         = rsp_tdata[21];
            got_rsp.byte_valid   = rsp_tuser[0];
            got_rsp.last         = rsp_tlast;
            results_checked++;
            if (uds_reply_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("transfer %0d arrived with nothing outstanding: tdata %0h",
                           results_checked, rsp_tdata);
            end else begin
               want_rsp = uds_reply_q.pop_front();
               check_field("payload_byte", want_rsp.payload_byte, got_rsp.payload_byte);
               check_field("byte_valid", want_rsp.byte_valid, got_rsp.byte_valid);
               check_field("last", want_rsp.last, got_rsp.last);
               check_field("frame_taken", want_rsp.frame_taken, got_rsp.frame_taken);
               check_field("send_flow_control", want_rsp.send_fc, got_rsp.send_fc);
               check_field("sequence_error", want_rsp.seq_err, got_rsp.seq_err);
               check_field("response_class", want_rsp.cls, got_rsp.cls);
               check_field("payload_length", want_rsp.plen, got_rsp.plen);
               check_field("request_done", want_rsp.done, got_rsp.done);
            end
            if (got_rsp.byte_valid === 1'b1) bytes_seen++;
            if (got_rsp.last === 1'b1) begin
               cls_seen[got_rsp.cls]++;
               if (got_rsp.seq_err === 1'b1) seq_errors++;
               if (got_rsp.send_fc === 1'b1) fc_requests++;
            end
         end
         stall_cyc++;
         if (stall_cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
         if (holdoff_seen != holdoff_token) begin
            holdoff_seen = holdoff_token;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            ready_next = 1'b0;
         end else begin
            case (stall_mode)
               0: ready_next = 1'b1;
               1: ready_next = 1'($urandom_range(0, 1));
               2: ready_next = (stall_cyc % 4 == 0);
               default: ready_next = ($urandom_range(0, 7) != 0);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // -------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         watchdog = 0;
      end else if (watchdog >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         watchdog++;
      end
   end

   // ------------------------------------------------------------- stimulus
   task automatic push_frame(input can_frame_type f);
      can_frame_q.push_back(f);
      frames_planned++;
   endtask

   task automatic queue_odd(input logic [FID_W-1:0] fid, input bit ext, input bit rtr,
                            input int flen, input logic [63:0] d);
      can_frame_type f;
      f.command      = CMD_FRAME;
      f.frame_id     = fid;
      f.is_extended  = ext;
      f.is_remote    = rtr;
      f.frame_length = FLEN_W'(flen);
      f.frame_data   = d;
      push_frame(f);
   endtask

   task automatic queue_frame(input int flen, input logic [63:0] d);
      queue_odd({18'd0, cfg_response_id}, 1'b0, 1'b0, flen, d);
   endtask

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd);
      can_frame_type f;
      f.command      = cmd;
      f.frame_id     = FID_W'($urandom);
      f.is_extended  = 1'($urandom_range(0, 1));
      f.is_remote    = 1'($urandom_range(0, 1));
      f.frame_length = FLEN_W'($urandom_range(0, 15));
      f.frame_data   = {$urandom, $urandom};
      push_frame(f);
   endtask

   task automatic queue_noise();
      can_frame_type f;
      f.command      = ($urandom_range(0, 9) < 8) ? CMD_FRAME : CMD_W'($urandom_range(1, 3));
      f.frame_id     = $urandom_range(0, 1) ? {18'd0, cfg_response_id} : FID_W'($urandom);
      f.is_extended  = ($urandom_range(0, 9) == 0);
      f.is_remote    = ($urandom_range(0, 9) == 0);
      f.frame_length = FLEN_W'($urandom_range(0, 15));
      f.frame_data   = {$urandom, $urandom};
      push_frame(f);
   endtask

   task automatic push_transfer(input bit big);
      logic [7:0]  body [72];
      logic [63:0] d;
      logic [11:0] ann;
      int          n, kind, pos, flen, seq, npend;
      bit          wrong;
      foreach (body[i]) body[i] = 8'($urandom);
      kind = $urandom_range(0, 99);
      if (big) n = PMAX;
      else if (kind < 75) n = $urandom_range(0, 20);
      else if (kind < 95) n = $urandom_range(21, PMAX - 1);
      else n = PMAX;
      kind = $urandom_range(0, 4);
      case (kind)
         0: body[0] = RSP_RDBI;
         1: body[0] = RSP_RDTC;
         2, 3: begin
            body[0] = SID_NEG_RSP;
            if ($urandom_range(0, 9) != 0) body[1] = $urandom_range(0, 1) ? SID_RDBI : SID_RDTC;
            if (kind == 3) body[2] = NRC_PENDING;
         end
         default: ;
      endcase
      if ($urandom_range(0, 9) != 0) queue_cmd(CMD_ARM);
      npend = ($urandom_range(0, 9) < 4) ? $urandom_range(1, 5) : 0;
      repeat (npend) begin
         d = {$urandom, $urandom};
         d[63:32] = {8'h03, SID_NEG_RSP, ($urandom_range(0, 1) ? SID_RDBI : SID_RDTC),
                     NRC_PENDING};
         queue_frame($urandom_range(4, 8), d);
      end
      if (n <= 7 && $urandom_range(0, 1)) begin
         d = {$urandom, $urandom};
         d[63:56] = 8'(n);
         for (int i = 0; i < 7; i++) d = put_byte(d, i + 1, body[i]);
         flen = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 15) : $urandom_range(n + 1, 8);
         queue_frame(flen, d);
      end else begin
         ann = 12'(n);
         if (n == PMAX && $urandom_range(0, 1)) ann = 12'($urandom_range(PMAX + 1, 4095));
         d = {$urandom, $urandom};
         d[63:48] = {PCI_FF[7:4], ann};
         for (int i = 0; i < 6; i++) d = put_byte(d, i + 2, body[i]);
         flen = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 15) : 8;
         queue_frame(flen, d);
         pos = ((flen > 8) ? 8 : flen) - 2;
         seq = 1;
         while (pos < n) begin
            if ($urandom_range(0, 39) == 0) begin
               queue_cmd(CMD_ABANDON);
               return;
            end
            if ($urandom_range(0, 19) == 0) queue_noise();
            wrong = ($urandom_range(0, 29) == 0);
            d = {$urandom, $urandom};
            d[63:56] = {PCI_CF[7:4], 4'(wrong ? seq + $urandom_range(1, 15) : seq)};
            for (int i = 0; i < 7; i++) d = put_byte(d, i + 1, body[pos + i]);
            flen = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 15) : 8;
            queue_frame(flen, d);
            if (wrong) return;
            pos += ((flen > 8) ? 8 : flen) - 1;
            seq = (seq + 1) % 16;
         end
         if ($urandom_range(0, 9) == 0) begin
            d = {$urandom, $urandom};
            d[63:56] = {PCI_CF[7:4], 4'(seq)};
            queue_frame(8, d);
         end
      end
   endtask

   task automatic random_phase(input int count, input bit big_first);
      int target;
      target = frames_planned + count;
      if (big_first) push_transfer(1'b1);
      while (frames_planned < target) begin
         if ($urandom_range(0, 9) < 7) push_transfer(1'b0);
         else repeat ($urandom_range(1, 4)) queue_noise();
      end
   endtask

   task automatic wait_drained();
      while (can_frame_q.size() > 0 || req_tvalid || uds_reply_q.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      if (idx == CSR_RESPONSE_ID) cfg_response_id = RSP_ID_W'(value);
      else cfg_max_pending = MAXP_W'(value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      foreach (cls_seen[i]) cls_seen[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_cmd(CMD_ARM);
      queue_frame(15, 64'h0462_F190_AB11_2233);
      queue_cmd(CMD_ARM);
      queue_frame(4, 64'h0359_0209_FFFF_FFFF);
      queue_cmd(CMD_ARM);
      queue_frame(8, 64'h037F_2278_0000_0000);
      queue_frame(2, 64'h0000_0000_0000_0000);
      queue_frame(3, 64'h0F7F_1931_0000_0000);
      queue_cmd(CMD_ARM);
      queue_odd({18'd0, cfg_response_id}, 1'b0, 1'b1, 8, 64'h0262_0100_0000_0000);
      queue_odd({18'd0, cfg_response_id}, 1'b1, 1'b0, 8, 64'h0262_0100_0000_0000);
      queue_odd({18'd0, cfg_response_id ^ 11'd1}, 1'b0, 1'b0, 8, 64'h0262_0100_0000_0000);
      queue_frame(1, 64'h0162_0000_0000_0000);
      queue_frame(2, 64'h1014_6201_0000_0000);
      queue_frame(8, 64'h2101_0203_0405_0607);
      queue_frame(8, 64'h3000_0000_0000_0000);
      queue_cmd(CMD_UNUSED);
      queue_frame(8, 64'h1000_6201_0203_0405);
      queue_frame(8, 64'h100A_6201_0203_0405);
      queue_frame(8, 64'h2206_0708_090A_0B0C);
      queue_cmd(CMD_ABANDON);
      queue_cmd(CMD_ARM);
      queue_cmd(CMD_ABANDON);
      wait_drained();

      write_csr(CSR_RESPONSE_ID, 2047);
      write_csr(CSR_MAX_PENDING, 0);
      random_phase(60, 1'b1);
      wait_drained();

      write_csr(CSR_RESPONSE_ID, 0);
      write_csr(CSR_MAX_PENDING, 15);
      holdoff_token++;
      random_phase(60, 1'b1);
      wait_drained();

      write_csr(CSR_RESPONSE_ID, $urandom_range(1, 2046));
      write_csr(CSR_MAX_PENDING, $urandom_range(1, 3));
      random_phase(60, 1'b0);
      wait_drained();

      repeat (20) @(posedge clock);
      $display("%0d frames sent, %0d output transfers checked, %0d payload bytes",
               frames_sent, results_checked, bytes_seen);
      $display("read %0d, dtc %0d, negative %0d, pending %0d, unrecognized %0d",
               cls_seen[CLS_READ], cls_seen[CLS_DTC], cls_seen[CLS_NEG], cls_seen[CLS_PEND],
               cls_seen[CLS_UNREC]);
      $display("sequence errors %0d, flow-control requests %0d", seq_errors, fc_requests);
      if (mismatches == 0 && uds_reply_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d transfers outstanding", mismatches, uds_reply_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### isotp_uds_response_receiver.f
rtl/core/isotp_pkg.sv
rtl/core/isotp_ctrl.sv
rtl/core/isotp_dp.sv
rtl/core/isotp_uds_response_receiver.sv
rtl/core/isotp_chk.sv
bench/isotp_uds_response_receiver_tb.sv
